// File: hw/rtl/gregorian_date_arithmetic_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian date arithmetic unit
// Property templates for the checks in the top-level file of the block.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger
`define GDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gregorian_date_arithmetic: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define GDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gregorian_date_arithmetic: next-cycle check failed");

`endif

// File: hw/rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Types, constants and calendar helpers for the date arithmetic unit.
// ----------------------------------------------------------------------------
package gda_pkg;

    // Calendar limits
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [22:0] TOTAL_DAYS = 23'd3652425;

    // Reciprocal of 100, exact for 15-bit inputs with a 19-bit shift
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    // Reciprocal of the mean year length, 2^23 / 365.2425
    localparam logic [14:0] EST_MUL    = 15'd22967;

    // Item modes
    localparam logic MODE_SHIFT = 1'b0;
    localparam logic MODE_CMP   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } st_code_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_YS1,
        OP_YS2,
        OP_YS3,
        OP_DATE_A,
        OP_DATE_B,
        OP_ADD,
        OP_EST,
        OP_YDEC,
        OP_YINC,
        OP_REM,
        OP_MSTEP,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_YS1,
        S_YS2,
        S_YS3,
        S_DATE_A,
        S_DATE_B,
        S_CHECK,
        S_RANGE,
        S_FIX,
        S_MWALK,
        S_CMP
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RET_A,
        RET_B,
        RET_SEARCH
    } ret_sel_t;

    typedef struct packed {
        dp_op_t   op;
        st_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic mode_cmp;
        logic a_invalid;
        logic b_invalid;
        logic out_of_range;
        logic ys_above;
        logic rem_past_year;
        logic month_more;
    } dp_sts_t;

    // Divide a value below 25600 by 100
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [27:0] prod;
        begin
            prod = 28'(x) * 28'(DIV100_MUL);
            return prod[26:19];
        end
    endfunction

    // Length of a month, zero for a month number outside 1..12
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                       len = leap ? 5'd29 : 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Days in a common year before the first of a month
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] cum;
        begin
            case (m)
                4'd2:    cum = 9'd31;
                4'd3:    cum = 9'd59;
                4'd4:    cum = 9'd90;
                4'd5:    cum = 9'd120;
                4'd6:    cum = 9'd151;
                4'd7:    cum = 9'd181;
                4'd8:    cum = 9'd212;
                4'd9:    cum = 9'd243;
                4'd10:   cum = 9'd273;
                4'd11:   cum = 9'd304;
                4'd12:   cum = 9'd334;
                default: cum = 9'd0;
            endcase
            return cum;
        end
    endfunction

endpackage

// File: hw/rtl/gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// Gregorian date unit: shift a date by a signed day count, or give the
// day distance and order of two dates.
//
//   Channel   Handshake          Fields
//   -------   ----------------   -------------------------------------------
//   command   start / busy       mode, year_a, month_a, day_a, offset_days,
//                                year_b, month_b, day_b
//   result    done (one cycle)   res_year, res_month, res_day, distance,
//                                a_greater, dates_equal, status
//
// A compare works out the year start and day number of each date, then
// finishes. A shift finishes early on a bad date or an out-of-range result;
// otherwise it estimates the year, steps it down or up until it fits, and
// walks the months. busy drops in the cycle done is shown, so a new command may
// transfer then. The receiver cannot hold off a result; it holds until
// the next done. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [13:0]        year_a,
    input  logic [3:0]         month_a,
    input  logic [4:0]         day_a,
    input  logic signed [22:0] offset_days,
    input  logic [13:0]        year_b,
    input  logic [3:0]         month_b,
    input  logic [4:0]         day_b,
    output logic               done,
    output logic [13:0]        res_year,
    output logic [3:0]         res_month,
    output logic [4:0]         res_day,
    output logic [21:0]        distance,
    output logic               a_greater,
    output logic               dates_equal,
    output logic [1:0]         status
);
    import gda_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer
    gda_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath
    gda_dpath u_dpath (
        .clk         (clk),
        .cmd         (cmd),
        .sts         (sts),
        .mode        (mode),
        .year_a      (year_a),
        .month_a     (month_a),
        .day_a       (day_a),
        .offset_days (offset_days),
        .year_b      (year_b),
        .month_b     (month_b),
        .day_b       (day_b),
        .res_year    (res_year),
        .res_month   (res_month),
        .res_day     (res_day),
        .distance    (distance),
        .a_greater   (a_greater),
        .dates_equal (dates_equal),
        .status      (status)
    );

    // Checks
`include "gregorian_date_arithmetic_assert.svh"

    `GDA_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `GDA_ASSERT_NEXT(a_transfer_busy, clk, rst_n, start && !busy, busy)
    `GDA_ASSERT_SAME(a_status_code, clk, rst_n, done, status == ST_OK || status == ST_BAD_DATE || status == ST_RANGE)
    `GDA_ASSERT_SAME(a_equal_dist, clk, rst_n, done && dates_equal, distance == 22'd0 && !a_greater)

endmodule

// File: hw/rtl/gda_ctrl.sv
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer for the date unit: steps the datapath through year-start,
// day-number, year search and month walk operations.
// ----------------------------------------------------------------------------
module gda_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gda_pkg::dp_sts_t sts,
    output gda_pkg::dp_cmd_t cmd,
    output logic            busy,
    output logic            done
);
    import gda_pkg::*;

    ctrl_state_t state_reg, state_next;
    ret_sel_t    ret_reg, ret_next;
    logic        done_reg;

    // State, return selector and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_A;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            done_reg  <= (cmd.op == OP_FINISH);
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NONE;
        cmd.code   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    ret_next   = RET_A;
                    state_next = S_YS1;
                end
            end
            S_YS1:
            begin
                cmd.op     = OP_YS1;
                state_next = S_YS2;
            end
            S_YS2:
            begin
                cmd.op     = OP_YS2;
                state_next = S_YS3;
            end
            S_YS3:
            begin
                cmd.op = OP_YS3;
                case (ret_reg)
                    RET_A:   state_next = S_DATE_A;
                    RET_B:   state_next = S_DATE_B;
                    default: state_next = S_FIX;
                endcase
            end
            S_DATE_A:
            begin
                cmd.op = OP_DATE_A;
                if (sts.mode_cmp)
                begin
                    ret_next   = RET_B;
                    state_next = S_YS1;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.a_invalid)
                begin
                    cmd.op     = OP_FINISH;
                    cmd.code   = ST_BAD_DATE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_ADD;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (sts.out_of_range)
                begin
                    cmd.op     = OP_FINISH;
                    cmd.code   = ST_RANGE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_EST;
                    ret_next   = RET_SEARCH;
                    state_next = S_YS1;
                end
            end
            S_FIX:
            begin
                if (sts.ys_above)
                begin
                    cmd.op     = OP_YDEC;
                    state_next = S_YS1;
                end
                else if (sts.rem_past_year)
                begin
                    cmd.op     = OP_YINC;
                    state_next = S_YS1;
                end
                else
                begin
                    cmd.op     = OP_REM;
                    state_next = S_MWALK;
                end
            end
            S_MWALK:
            begin
                if (sts.month_more)
                begin
                    cmd.op = OP_MSTEP;
                end
                else
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            S_DATE_B:
            begin
                cmd.op     = OP_DATE_B;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.op     = OP_FINISH;
                cmd.code   = (sts.a_invalid || sts.b_invalid) ? ST_BAD_DATE : ST_OK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: hw/rtl/gda_dpath.sv
// ----------------------------------------------------------------------------
// gda_dpath
// Datapath for the date unit: input capture, year-start and leap
// evaluation, day numbers, year estimate and search, month walk, results.
// ----------------------------------------------------------------------------
module gda_dpath (
    input  logic                    clk,
    input  gda_pkg::dp_cmd_t        cmd,
    output gda_pkg::dp_sts_t        sts,
    input  logic                    mode,
    input  logic [13:0]             year_a,
    input  logic [3:0]              month_a,
    input  logic [4:0]              day_a,
    input  logic signed [22:0]      offset_days,
    input  logic [13:0]             year_b,
    input  logic [3:0]              month_b,
    input  logic [4:0]              day_b,
    output logic [13:0]             res_year,
    output logic [3:0]              res_month,
    output logic [4:0]              res_day,
    output logic [21:0]             distance,
    output logic                    a_greater,
    output logic                    dates_equal,
    output logic [1:0]              status
);
    import gda_pkg::*;

    // Captured item
    logic               mode_reg;
    logic [13:0]        ya_reg, yb_reg;
    logic [3:0]         ma_reg, mb_reg;
    logic [4:0]         da_reg, db_reg;
    logic signed [22:0] off_reg;

    // Working registers
    logic [13:0]        yr_reg;
    logic [7:0]         q_reg, b_reg;
    logic [22:0]        ys_reg;
    logic               leap_reg;
    logic [22:0]        na_reg, nb_reg;
    logic               a_ok_reg, b_ok_reg;
    logic signed [23:0] n_reg;
    logic [3:0]         mo_reg;

    // Result registers
    logic [13:0]        res_year_reg;
    logic [3:0]         res_month_reg;
    logic [4:0]         res_day_reg;
    logic [21:0]        distance_reg;
    logic               a_greater_reg, dates_equal_reg;
    logic [1:0]         status_reg;

    // Year-start terms
    logic [14:0] yr_p99, yr_p399, yr_p3, b_hund;
    logic [22:0] yr_x365, ys_sum;
    logic        hund_year, leap_calc;

    // Day numbers
    logic [4:0]  dim_a, dim_b, dim_cur;
    logic        valid_a, valid_b;
    logic [22:0] num_a, num_b;

    // Search and compare
    logic [23:0]        ys_ext;
    logic signed [23:0] rem_s, sum_s;
    logic [8:0]         diy;
    logic [36:0]        est_prod;
    logic [13:0]        est_year;
    logic [22:0]        diff;
    logic               date_ok, cmp_ok;

    // Year start: 365y + ceil(y/4) - ceil(y/100) + ceil(y/400)
    assign yr_p99  = 15'(yr_reg) + 15'd99;
    assign yr_p399 = 15'(yr_reg) + 15'd399;
    assign yr_p3   = 15'(yr_reg) + 15'd3;
    assign yr_x365 = 23'({yr_reg, 8'b0}) + 23'({yr_reg, 6'b0}) + 23'({yr_reg, 5'b0})
                   + 23'({yr_reg, 3'b0}) + 23'({yr_reg, 2'b0}) + 23'(yr_reg);
    assign ys_sum  = yr_x365 + 23'(yr_p3[14:2]) - 23'(b_reg) + 23'(q_reg);

    // Leap year: b holds ceil(y/100), so y is a century year when b*100 == y
    assign b_hund    = 15'({b_reg, 6'b0}) + 15'({b_reg, 5'b0}) + 15'({b_reg, 2'b0});
    assign hund_year = (b_hund == 15'(yr_reg));
    assign leap_calc = hund_year ? (b_reg[1:0] == 2'd0) : (yr_reg[1:0] == 2'd0);

    // Validate and number the primary and second dates
    assign dim_a   = days_in_month(ma_reg, leap_reg);
    assign dim_b   = days_in_month(mb_reg, leap_reg);
    assign valid_a = (ya_reg <= YEAR_MAX) && (dim_a != 5'd0) && (da_reg != 5'd0)
                  && (da_reg <= dim_a);
    assign valid_b = (yb_reg <= YEAR_MAX) && (dim_b != 5'd0) && (db_reg != 5'd0)
                  && (db_reg <= dim_b);
    assign num_a   = ys_reg + 23'(days_before_month(ma_reg))
                   + 23'(leap_reg && (ma_reg > 4'd2)) + 23'(da_reg) - 23'd1;
    assign num_b   = ys_reg + 23'(days_before_month(mb_reg))
                   + 23'(leap_reg && (mb_reg > 4'd2)) + 23'(db_reg) - 23'd1;

    // Shifted day number and year estimate
    assign sum_s    = $signed({1'b0, na_reg}) + $signed({off_reg[22], off_reg});
    assign est_prod = 37'(n_reg[21:0]) * 37'(EST_MUL);
    assign est_year = (est_prod[36:23] > YEAR_MAX) ? YEAR_MAX : est_prod[36:23];

    // Year search and month walk tests
    assign ys_ext  = {1'b0, ys_reg};
    assign rem_s   = n_reg - $signed(ys_ext);
    assign diy     = leap_reg ? 9'd366 : 9'd365;
    assign dim_cur = days_in_month(mo_reg, leap_reg);

    assign sts.mode_cmp      = (mode_reg == MODE_CMP);
    assign sts.a_invalid     = !a_ok_reg;
    assign sts.b_invalid     = !b_ok_reg;
    assign sts.out_of_range  = (n_reg < 24'sd0) || (n_reg >= $signed({1'b0, TOTAL_DAYS}));
    assign sts.ys_above      = ($signed(ys_ext) > n_reg);
    assign sts.rem_past_year = !sts.ys_above && (rem_s[22:0] >= 23'(diy));
    assign sts.month_more    = (mo_reg != 4'd12) && (n_reg >= $signed({19'b0, dim_cur}));

    // Compare results
    assign diff    = (na_reg >= nb_reg) ? (na_reg - nb_reg) : (nb_reg - na_reg);
    assign date_ok = (mode_reg == MODE_SHIFT) && (cmd.code == ST_OK);
    assign cmp_ok  = (mode_reg == MODE_CMP) && (cmd.code == ST_OK);

    // Execute the command of this cycle
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg <= mode;
                ya_reg   <= year_a;
                ma_reg   <= month_a;
                da_reg   <= day_a;
                off_reg  <= offset_days;
                yb_reg   <= year_b;
                mb_reg   <= month_b;
                db_reg   <= day_b;
                yr_reg   <= year_a;
            end
            OP_YS1:
            begin
                q_reg <= div100(yr_p99);
            end
            OP_YS2:
            begin
                b_reg <= q_reg;
                q_reg <= div100({2'b0, yr_p399[14:2]});
            end
            OP_YS3:
            begin
                ys_reg   <= ys_sum;
                leap_reg <= leap_calc;
            end
            OP_DATE_A:
            begin
                na_reg   <= num_a;
                a_ok_reg <= valid_a;
                yr_reg   <= yb_reg;
            end
            OP_DATE_B:
            begin
                nb_reg   <= num_b;
                b_ok_reg <= valid_b;
            end
            OP_ADD:
            begin
                n_reg <= sum_s;
            end
            OP_EST:
            begin
                yr_reg <= est_year;
            end
            OP_YDEC:
            begin
                yr_reg <= yr_reg - 14'd1;
            end
            OP_YINC:
            begin
                yr_reg <= yr_reg + 14'd1;
            end
            OP_REM:
            begin
                n_reg  <= rem_s;
                mo_reg <= 4'd1;
            end
            OP_MSTEP:
            begin
                n_reg  <= n_reg - $signed({19'b0, dim_cur});
                mo_reg <= mo_reg + 4'd1;
            end
            OP_FINISH:
            begin
                res_year_reg    <= date_ok ? yr_reg : ya_reg;
                res_month_reg   <= date_ok ? mo_reg : ma_reg;
                res_day_reg     <= date_ok ? (n_reg[4:0] + 5'd1) : da_reg;
                distance_reg    <= cmp_ok ? diff[21:0] : 22'd0;
                a_greater_reg   <= cmp_ok && (na_reg > nb_reg);
                dates_equal_reg <= cmp_ok && (na_reg == nb_reg);
                status_reg      <= cmd.code;
            end
            default:
            begin
            end
        endcase
    end

    assign res_year    = res_year_reg;
    assign res_month   = res_month_reg;
    assign res_day     = res_day_reg;
    assign distance    = distance_reg;
    assign a_greater   = a_greater_reg;
    assign dates_equal = dates_equal_reg;
    assign status      = status_reg;

endmodule

// File: tb/tb_gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// tb_gregorian_date_arithmetic
// Self-checking bench for the date arithmetic unit. Commands go in over the
// start/busy handshake, with random gaps between them. A calendar model in
// the bench works out the shifted date, or the distance and order of two
// dates, for every transfer, and each done strobe is checked against the
// oldest pending answer. Directed corner dates come first, then about a
// thousand random commands, mostly well-formed with some broken and raw ones.
// ----------------------------------------------------------------------------
module tb_gregorian_date_arithmetic;

    import gda_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic               mode;
        logic [13:0]        ya;
        logic [3:0]         ma;
        logic [4:0]         da;
        logic signed [22:0] off;
        logic [13:0]        yb;
        logic [3:0]         mb;
        logic [4:0]         db;
    } date_cmd_t;

    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] span;
        logic        gt;
        logic        eq;
        logic [1:0]  st;
    } date_res_t;

    // Calendar model and pending-answer store
    class calendar_checker;
        localparam longint DAY_SPAN = 3652425;

        date_res_t expected_dates[$];
        int        errors;
        int        shifts;
        int        compares;
        int        bad_dates;
        int        out_of_range;

        function bit leap_year(longint y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned month_len(longint y, int unsigned m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        function bit date_ok(int unsigned y, int unsigned m, int unsigned d);
            if (y > 9999 || m < 1 || m > 12)
                return 1'b0;
            return d >= 1 && d <= month_len(y, m);
        endfunction

        // Days from 0000-01-01 to the first of January of year y
        function longint year_base(longint y);
            return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        endfunction

        function longint day_index(int unsigned y, int unsigned m, int unsigned d);
            longint n;
            n = year_base(y);
            for (int unsigned k = 1; k < m && k <= 12; k++)
                n += month_len(y, k);
            return n + d - 1;
        endfunction

        function void index_to_date(input longint n, output int unsigned y,
                                    output int unsigned m, output int unsigned d);
            longint yy;
            longint rest;
            int unsigned mm;
            // n / 366 never overshoots the year, so only step upward
            yy = n / 366;
            while (yy < 9999 && year_base(yy + 1) <= n)
                yy++;
            rest = n - year_base(yy);
            mm = 1;
            while (mm < 12 && rest >= month_len(yy, mm))
            begin
                rest -= month_len(yy, mm);
                mm++;
            end
            y = int'(yy);
            m = mm;
            d = int'(rest) + 1;
        endfunction

        function date_res_t work_out_date(date_cmd_t c);
            date_res_t r;
            longint na;
            longint nb;
            int unsigned y;
            int unsigned m;
            int unsigned d;
            r.year  = c.ya;
            r.month = c.ma;
            r.day   = c.da;
            r.span  = '0;
            r.gt    = 1'b0;
            r.eq    = 1'b0;
            r.st    = ST_OK;
            if (c.mode == MODE_SHIFT)
            begin
                if (!date_ok(c.ya, c.ma, c.da))
                    r.st = ST_BAD_DATE;
                else
                begin
                    na = day_index(c.ya, c.ma, c.da) + longint'(c.off);
                    if (na < 0 || na >= DAY_SPAN)
                        r.st = ST_RANGE;
                    else
                    begin
                        index_to_date(na, y, m, d);
                        r.year  = 14'(y);
                        r.month = 4'(m);
                        r.day   = 5'(d);
                    end
                end
            end
            else if (!date_ok(c.ya, c.ma, c.da) || !date_ok(c.yb, c.mb, c.db))
                r.st = ST_BAD_DATE;
            else
            begin
                na = day_index(c.ya, c.ma, c.da);
                nb = day_index(c.yb, c.mb, c.db);
                r.span = 22'(na >= nb ? na - nb : nb - na);
                r.gt   = na > nb;
                r.eq   = na == nb;
            end
            return r;
        endfunction

        // Note a command transfer and queue its answer
        function void note_command(date_cmd_t c);
            date_res_t r;
            r = work_out_date(c);
            if (c.mode == MODE_SHIFT)
                shifts++;
            else
                compares++;
            if (r.st == ST_BAD_DATE)
                bad_dates++;
            if (r.st == ST_RANGE)
                out_of_range++;
            expected_dates.push_back(r);
        endfunction

        function void match(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", fname, want, got);
                errors++;
            end
        endfunction

        // Check one done strobe against the oldest pending answer
        function void check_result(date_res_t got);
            date_res_t want;
            if (expected_dates.size() == 0)
            begin
                $error("result strobe with no command pending");
                errors++;
                return;
            end
            want = expected_dates.pop_front();
            match("res_year",    want.year,  got.year);
            match("res_month",   want.month, got.month);
            match("res_day",     want.day,   got.day);
            match("distance",    want.span,  got.span);
            match("a_greater",   want.gt,    got.gt);
            match("dates_equal", want.eq,    got.eq);
            match("status",      want.st,    got.st);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               mode = MODE_SHIFT;
    logic [13:0]        year_a = '0;
    logic [3:0]         month_a = '0;
    logic [4:0]         day_a = '0;
    logic signed [22:0] offset_days = '0;
    logic [13:0]        year_b = '0;
    logic [3:0]         month_b = '0;
    logic [4:0]         day_b = '0;
    logic               busy;
    logic               done;
    logic [13:0]        res_year;
    logic [3:0]         res_month;
    logic [4:0]         res_day;
    logic [21:0]        distance;
    logic               a_greater;
    logic               dates_equal;
    logic [1:0]         status;

    calendar_checker checker_h = new();
    date_cmd_t       directed_cmds[$];
    date_cmd_t       taken;
    date_res_t       seen;
    int              idle_cycles = 0;

    int unsigned EDGE_YEARS[14] = '{0, 1, 4, 99, 100, 399, 400, 1600, 1700,
                                    1900, 2000, 2100, 9996, 9999};

    gregorian_date_arithmetic dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .year_a      (year_a),
        .month_a     (month_a),
        .day_a       (day_a),
        .offset_days (offset_days),
        .year_b      (year_b),
        .month_b     (month_b),
        .day_b       (day_b),
        .done        (done),
        .res_year    (res_year),
        .res_month   (res_month),
        .res_day     (res_day),
        .distance    (distance),
        .a_greater   (a_greater),
        .dates_equal (dates_equal),
        .status      (status)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check results first, then record the command taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                seen.year  = res_year;
                seen.month = res_month;
                seen.day   = res_day;
                seen.span  = distance;
                seen.gt    = a_greater;
                seen.eq    = dates_equal;
                seen.st    = status;
                checker_h.check_result(seen);
            end
            if (start && !busy)
            begin
                taken.mode = mode;
                taken.ya   = year_a;
                taken.ma   = month_a;
                taken.da   = day_a;
                taken.off  = offset_days;
                taken.yb   = year_b;
                taken.mb   = month_b;
                taken.db   = day_b;
                checker_h.note_command(taken);
            end
        end
    end

    // Watchdog: give up after a long stretch with no transfer and no result
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no activity for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic date_cmd_t mk(logic md, int unsigned ya, int unsigned ma,
                                     int unsigned da, longint off, int unsigned yb,
                                     int unsigned mb, int unsigned db);
        date_cmd_t c;
        c.mode = md;
        c.ya   = 14'(ya);
        c.ma   = 4'(ma);
        c.da   = 5'(da);
        c.off  = 23'(off);
        c.yb   = 14'(yb);
        c.mb   = 4'(mb);
        c.db   = 5'(db);
        return c;
    endfunction

    // Pick a valid date, leaning toward century years, February and month ends
    function automatic void pick_date(output int unsigned y, output int unsigned m,
                                      output int unsigned d);
        int unsigned len;
        y = ($urandom_range(0, 4) == 0) ? EDGE_YEARS[$urandom_range(0, 13)]
                                        : $urandom_range(0, 9999);
        m = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
        len = checker_h.month_len(y, m);
        d = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
    endfunction

    function automatic date_cmd_t random_cmd();
        date_cmd_t   c;
        int unsigned ya, ma, da, yb, mb, db;
        int unsigned kind;
        int unsigned pick;
        int unsigned len;
        longint      off;
        longint      base;
        kind = $urandom_range(0, 99);
        pick_date(ya, ma, da);
        pick_date(yb, mb, db);

        // Offset: short hops, longer ones, full-range ones, some aimed at the range ends
        pick = $urandom_range(0, 9);
        if (pick < 3)
            off = longint'($urandom_range(0, 120)) - 60;
        else if (pick < 5)
            off = longint'($urandom_range(0, 4000)) - 2000;
        else if (pick < 7)
            off = longint'($urandom_range(0, 7304848)) - 3652424;
        else if (pick < 9)
        begin
            base = checker_h.day_index(ya, ma, da);
            off  = ($urandom_range(0, 1) ? -base : 3652424 - base)
                 + longint'($urandom_range(0, 6)) - 3;
        end
        else
            off = longint'($urandom_range(0, 8388607)) - 4194304;

        // Second date: same day, same month, or anywhere
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            yb = ya;
            mb = ma;
            db = da;
        end
        else if (pick < 4)
        begin
            yb = ya;
            mb = ma;
            db = $urandom_range(1, checker_h.month_len(ya, ma));
        end

        c = mk($urandom_range(0, 1), ya, ma, da, off, yb, mb, db);

        // Raw noise on every date and offset field
        if (kind < 12)
        begin
            c.ya  = 14'($urandom);
            c.ma  = 4'($urandom);
            c.da  = 5'($urandom);
            c.off = 23'($urandom);
            c.yb  = 14'($urandom);
            c.mb  = 4'($urandom);
            c.db  = 5'($urandom);
        end
        // Break one field of one date
        else if (kind < 27)
        begin
            pick = $urandom_range(0, 3);
            if (c.mode == MODE_CMP && $urandom_range(0, 1))
            begin
                len = checker_h.month_len(yb, mb);
                case (pick)
                    0: c.db = '0;
                    1: c.db = 5'((len < 31) ? $urandom_range(len + 1, 31) : 0);
                    2: c.mb = 4'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(13, 15));
                    default: c.yb = 14'($urandom_range(10000, 16383));
                endcase
            end
            else
            begin
                len = checker_h.month_len(ya, ma);
                case (pick)
                    0: c.da = '0;
                    1: c.da = 5'((len < 31) ? $urandom_range(len + 1, 31) : 0);
                    2: c.ma = 4'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(13, 15));
                    default: c.ya = 14'($urandom_range(10000, 16383));
                endcase
            end
        end
        return c;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one command at a falling edge and hold it until it transfers
    task automatic send_cmd(input date_cmd_t c, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode        <= c.mode;
        year_a      <= c.ya;
        month_a     <= c.ma;
        day_a       <= c.da;
        offset_days <= c.off;
        year_b      <= c.yb;
        month_b     <= c.mb;
        day_b       <= c.db;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    initial
    begin
        // Range ends and zero shifts
        directed_cmds.push_back(mk(MODE_SHIFT, 0, 1, 1, -1, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 9999, 12, 31, 1, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 0, 1, 1, 0, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 0, 1, 1, 3652424, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 9999, 12, 31, -3652424, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 0, 1, 1, 4194303, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 9999, 12, 31, -4194304, 0, 1, 1));
        // Leap-year February: 400-rule, 100-rule, year zero; a year rollover
        directed_cmds.push_back(mk(MODE_SHIFT, 2000, 2, 28, 1, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 1900, 2, 28, 1, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 2024, 3, 1, -1, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 0, 2, 29, 366, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 1999, 12, 31, 1, 0, 1, 1));
        // Invalid primary dates
        directed_cmds.push_back(mk(MODE_SHIFT, 1900, 2, 29, 5, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 2020, 0, 10, 5, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 2020, 15, 10, 5, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 2020, 4, 31, 5, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 2020, 5, 0, 5, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_SHIFT, 16383, 15, 31, -1, 0, 1, 1));
        // Compares: equal, both orders, widest span, bad dates
        directed_cmds.push_back(mk(MODE_CMP, 2000, 2, 29, 0, 2000, 2, 29));
        directed_cmds.push_back(mk(MODE_CMP, 2001, 3, 1, 0, 2000, 2, 29));
        directed_cmds.push_back(mk(MODE_CMP, 0, 1, 1, 0, 9999, 12, 31));
        directed_cmds.push_back(mk(MODE_CMP, 9999, 12, 31, 0, 0, 1, 1));
        directed_cmds.push_back(mk(MODE_CMP, 2020, 1, 1, 0, 10000, 1, 1));
        directed_cmds.push_back(mk(MODE_CMP, 2021, 2, 29, 0, 2020, 1, 1));
        directed_cmds.push_back(mk(MODE_CMP, 2020, 1, 1, -1, 2020, 13, 0));

        // Hold reset, then release at a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i], gap_cycles());

        // Random commands, with one back-to-back stretch
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_cmd(random_cmd(), (i >= 300 && i < 450) ? 0 : gap_cycles());
        start <= 1'b0;

        // Drain, then watch a little longer for stray strobes
        while (checker_h.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d shifts and %0d compares", checker_h.shifts,
                 checker_h.compares);
        $display("of these %0d had a bad date and %0d left the year range",
                 checker_h.bad_dates, checker_h.out_of_range);
        if (checker_h.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
